### hw/rtl/grbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbr_pkg: shared types and helpers for the gamma run-length block rank core
// Request and response words, block type codes, state codes, step results.
// ----------------------------------------------------------------------------
package grbr_pkg;

    localparam int GRBR_STORE_WORDS = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] BT_RUNS_ZERO = 3'd0;
    localparam logic [2:0] BT_RUNS_ONE  = 3'd1;
    localparam logic [2:0] BT_PLAIN     = 3'd2;
    localparam logic [2:0] BT_ZEROS     = 3'd3;
    localparam logic [2:0] BT_ONES      = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [9:0]  word_address;
        logic [63:0] word_value;
        logic [2:0]  block_type;
        logic [15:0] start_bit;
        logic [8:0]  rank_len;
    } req_t;

    typedef struct packed {
        logic [8:0] ones_count;
        logic       last_bit;
    } rsp_t;

    // outcome of one pass of the shared decode unit
    typedef struct packed {
        logic [6:0]  adv;       // bits consumed
        logic [16:0] run_len;   // gamma run length, at least 1
        logic [6:0]  ones;      // popcount of the leading bits (plain)
        logic        last;      // last counted bit (plain)
    } step_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_LOADA  = 7'b0000100,
        ST_LOADB  = 7'b0001000,
        ST_LOADC  = 7'b0010000,
        ST_RUN    = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    function automatic logic [6:0] popcount64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [6:0]  s;
        a = x - ((x >> 1) & 64'h5555555555555555);
        b = (a & 64'h3333333333333333) + ((a >> 2) & 64'h3333333333333333);
        c = (b + (b >> 4)) & 64'h0F0F0F0F0F0F0F0F;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 7'(c[8*i +: 8]);
        end
        return s;
    endfunction

endpackage

### hw/rtl/grbr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbr_step: shared decode unit
// Decodes one gamma code, or counts up to 64 plain bits, from a bit window.
// ----------------------------------------------------------------------------
module grbr_step
    import grbr_pkg::*;
(
    input  logic [63:0] window,
    input  logic        plain,
    input  logic [8:0]  remain,
    output step_t       step
);

    logic [4:0]  zeros;
    logic        found;
    logic [32:0] code;
    logic [32:0] value;
    logic [6:0]  take;
    logic [63:0] mask;
    logic [5:0]  last_idx;

    always_comb
    begin
        zeros = 5'd16;
        found = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            if (!found && window[63 - i])
            begin
                zeros = 5'(i);
                found = 1'b1;
            end
        end
        // top 2z+1 bits hold the code; the prefix zeros add nothing
        code  = window[63:31];
        value = code >> (6'd32 - {zeros, 1'b0});

        take     = (remain > 9'd64) ? 7'd64 : remain[6:0];
        mask     = ~({64{1'b1}} >> take);
        last_idx = 6'(7'd64 - take);

        step.run_len = (value[16:0] == 17'd0) ? 17'd1 : value[16:0];
        step.adv     = plain ? 7'd64 : ({1'b0, zeros, 1'b0} + 7'd1);
        step.ones    = popcount64(window & mask);
        step.last    = window[last_idx];
    end

endmodule

### hw/rtl/gamma_rle_block_rank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_rle_block_rank_core: rank over gamma run-length / plain bit blocks
// Write words fill a 64-bit store; queries rank one block held in it.
// ----------------------------------------------------------------------------
// Write: start-address wrap steps (none while the address fits), then the write.
// Query, runs/plain: wrap steps, fetch states LOADA/LOADB/LOADC, then one step
//   per gamma code or per 64 plain bits, one reload per store word crossed, and
//   the result post. The single store read port and the one-code-per-cycle
//   decode unit set its pace. Query, types 3/4/unknown or count zero: result set directly. One word at a time.
// Reset clears control and output valid; store contents undefined until written.
// ----------------------------------------------------------------------------
module gamma_rle_block_rank_core
    import grbr_pkg::*;
#(
    parameter int STORE_WORDS = GRBR_STORE_WORDS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // word index width, bit position width, and width for the wrap compare
    localparam int AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int POS_W = AW + 6;
    localparam int CMP_W = (POS_W + 1 > 17) ? POS_W + 1 : 17;

    localparam logic [CMP_W-1:0] TOTAL_BITS = CMP_W'(STORE_WORDS * 64);
    localparam logic [CMP_W-1:0] WORDS_C    = CMP_W'(STORE_WORDS);
    localparam logic [AW-1:0]    LAST_WORD  = AW'(STORE_WORDS - 1);

    function automatic logic [AW-1:0] next_word(input logic [AW-1:0] w);
        return (w == LAST_WORD) ? '0 : w + 1'b1;
    endfunction

    // encoded store: one write and one registered read per cycle
    logic [63:0] store [STORE_WORDS];
    logic [63:0] rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // control
    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // payload / datapath
    logic             op_reg, op_next;
    logic [CMP_W-1:0] red_reg, red_next;
    logic [63:0]      data_reg, data_next;
    logic [AW-1:0]    widx_reg, widx_next;
    logic [5:0]       off_reg, off_next;
    logic [63:0]      hi_reg, hi_next;
    logic [63:0]      lo_reg, lo_next;
    logic [8:0]       rem_reg, rem_next;
    logic [8:0]       acc_reg, acc_next;
    logic             cur_reg, cur_next;
    logic             plain_reg, plain_next;
    logic [8:0]       res_ones_reg, res_ones_next;
    logic             res_last_reg, res_last_next;
    rsp_t             rsp_reg, rsp_next;

    logic [AW-1:0]    nw;
    logic [AW-1:0]    nnw;
    logic [CMP_W-1:0] modulus;
    logic [127:0]     pair;
    logic [63:0]      window;
    logic [6:0]       off_sum;
    step_t            step;

    assign nw      = next_word(widx_reg);
    assign nnw     = next_word(nw);
    assign modulus = (op_reg == OP_QUERY) ? TOTAL_BITS : WORDS_C;
    assign pair    = {hi_reg, lo_reg} << off_reg;
    assign window  = pair[127:64];

    grbr_step u_step (
        .window (window),
        .plain  (plain_reg),
        .remain (rem_reg),
        .step   (step)
    );

    assign off_sum = {1'b0, off_reg} + step.adv;

    // read address follows the fetch sequence
    always_comb
    begin
        case (state_reg)
            ST_LOADA: rd_addr = widx_reg;
            ST_LOADB: rd_addr = nw;
            ST_RUN:   rd_addr = nnw;
            default:  rd_addr = widx_reg;
        endcase
    end

    assign mem_we = (state_reg == ST_REDUCE) && (op_reg == OP_WRITE) && (red_reg < modulus);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[red_reg[AW-1:0]] <= data_reg;
        end
        rdata_reg <= store[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        red_next       = red_reg;
        data_next      = data_reg;
        widx_next      = widx_reg;
        off_next       = off_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        cur_next       = cur_reg;
        plain_next     = plain_reg;
        res_ones_next  = res_ones_reg;
        res_last_next  = res_last_reg;
        rsp_next       = rsp_reg;

        // output word taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    data_next  = req.word_value;
                    rem_next   = req.rank_len;
                    acc_next   = '0;
                    cur_next   = (req.block_type == BT_RUNS_ONE);
                    plain_next = (req.block_type == BT_PLAIN);
                    if (req.operation == OP_WRITE)
                    begin
                        red_next   = CMP_W'(req.word_address);
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        red_next = CMP_W'(req.start_bit);
                        if (req.rank_len == 9'd0)
                        begin
                            res_ones_next = '0;
                            res_last_next = 1'b0;
                            state_next    = ST_RESULT;
                        end
                        else
                        begin
                            case (req.block_type)
                                BT_RUNS_ZERO, BT_RUNS_ONE, BT_PLAIN:
                                begin
                                    state_next = ST_REDUCE;
                                end
                                BT_ONES:
                                begin
                                    res_ones_next = req.rank_len;
                                    res_last_next = 1'b1;
                                    state_next    = ST_RESULT;
                                end
                                default:
                                begin
                                    // all zeros, and codes with no meaning
                                    res_ones_next = '0;
                                    res_last_next = 1'b0;
                                    state_next    = ST_RESULT;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_REDUCE:
            begin
                // wrap address into the store, one subtract a cycle
                if (red_reg >= modulus)
                begin
                    red_next = red_reg - modulus;
                end
                else if (op_reg == OP_WRITE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    widx_next  = red_reg[POS_W-1:6];
                    off_next   = red_reg[5:0];
                    state_next = ST_LOADA;
                end
            end

            ST_LOADA:
            begin
                state_next = ST_LOADB;
            end

            ST_LOADB:
            begin
                hi_next    = rdata_reg;
                state_next = ST_LOADC;
            end

            ST_LOADC:
            begin
                lo_next    = rdata_reg;
                state_next = ST_RUN;
            end

            ST_RUN:
            begin
                if (plain_reg)
                begin
                    if (rem_reg <= 9'd64)
                    begin
                        res_ones_next = acc_reg + 9'(step.ones);
                        res_last_next = step.last;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        acc_next = acc_reg + 9'(step.ones);
                        rem_next = rem_reg - 9'd64;
                    end
                end
                else
                begin
                    if (step.run_len >= {8'd0, rem_reg})
                    begin
                        res_ones_next = cur_reg ? (acc_reg + rem_reg) : acc_reg;
                        res_last_next = cur_reg;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        rem_next = rem_reg - step.run_len[8:0];
                        if (cur_reg)
                        begin
                            acc_next = acc_reg + step.run_len[8:0];
                        end
                        cur_next = ~cur_reg;
                    end
                end

                // advance; a word crossing shifts the pair and fetches ahead
                if (state_next == ST_RUN)
                begin
                    off_next = off_sum[5:0];
                    if (off_sum[6])
                    begin
                        hi_next    = lo_reg;
                        widx_next  = nw;
                        state_next = ST_LOADC;
                    end
                end
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.ones_count = res_ones_reg;
                    rsp_next.last_bit   = res_last_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        red_reg      <= red_next;
        data_reg     <= data_next;
        widx_reg     <= widx_next;
        off_reg      <= off_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        cur_reg      <= cur_next;
        plain_reg    <= plain_next;
        res_ones_reg <= res_ones_next;
        res_last_reg <= res_last_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
